// File: src/rpa_pkg.sv
// Shared types and constants for the reference-counted page allocator.
// Holds op and status codes, the sequencer state encoding and the update control struct.
// No dependencies.
package rpa_pkg;

  // Fixed field widths
  localparam int unsigned AddrW     = 22;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned RefOutW   = 8;
  localparam int unsigned RegW      = 11;
  localparam int unsigned WideW     = 32;

  // Reset value of the first usable page register
  localparam logic [RegW-1:0] FirstUsableReset = 11'd64;

  // Request kinds; the remaining code is answered as a bad address
  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_REF   = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_NOMEM   = 3'd1,
    ST_BADADDR = 3'd2,
    ST_UNDER   = 3'd3,
    ST_SAT     = 3'd4
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  // Side effects decided for one transaction
  typedef struct packed {
    logic cnt_we;      // write the page count memory
    logic push;        // push page onto the freed stack
    logic pop;         // pop the freed stack
    logic take_fresh;  // take the next never-used page
  } upd_ctrl_t;

endpackage

// File: src/rpa_update.sv
// Request decode and count update for the page allocator.
// Works on the count and stack words read from memory; purely combinational.
// Depends on rpa_pkg.
module rpa_update #(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_REFS   = 255
) (
  input  rpa_pkg::op_e                            op_i,
  input  logic [rpa_pkg::AddrW-1:0]               addr_i,
  input  logic [rpa_pkg::RegW-1:0]                first_usable_i,
  input  logic [$clog2(MAX_REFS+1)-1:0]           count_rd_i,
  input  logic [$clog2(NUM_PAGES)-1:0]            stack_rd_i,
  input  logic [$clog2(NUM_PAGES):0]              depth_i,
  input  logic [$clog2(NUM_PAGES):0]              fresh_i,
  output rpa_pkg::upd_ctrl_t                      ctrl_o,
  output logic [$clog2(NUM_PAGES)-1:0]            page_o,
  output logic [$clog2(MAX_REFS+1)-1:0]           count_wr_o,
  output rpa_pkg::status_e                        status_o,
  output logic [rpa_pkg::AddrW-1:0]               page_addr_o,
  output logic [rpa_pkg::RefOutW-1:0]             ref_count_o
);
  import rpa_pkg::*;

  localparam int unsigned IdxW      = $clog2(NUM_PAGES);
  localparam int unsigned CntW      = $clog2(MAX_REFS + 1);
  localparam int unsigned PageShift = $clog2(PAGE_BYTES);

  logic [WideW-1:0] pfn_w;
  logic [WideW-1:0] first_w;
  logic [WideW-1:0] fresh_w;
  logic             misaligned;
  logic             in_range;
  logic             depth_full;
  logic [IdxW:0]    fresh_dec;
  logic [CntW-1:0]  count_show;
  logic             show_page;
  logic [WideW-1:0] page_w;
  logic [WideW-1:0] count_w;

  // Address checks
  assign pfn_w      = WideW'(addr_i[AddrW-1:PageShift]);
  assign first_w    = WideW'(first_usable_i);
  assign fresh_w    = WideW'(fresh_i);
  assign misaligned = |addr_i[PageShift-1:0];
  assign in_range   = !misaligned && (pfn_w >= first_w) && (pfn_w < WideW'(NUM_PAGES));
  assign depth_full = (depth_i == (IdxW+1)'(NUM_PAGES));
  assign fresh_dec  = fresh_i - 1'b1;

  // Decide the side effects and the answer
  always_comb begin
    ctrl_o     = '0;
    page_o     = pfn_w[IdxW-1:0];
    count_wr_o = count_rd_i;
    status_o   = ST_BADADDR;
    show_page  = 1'b0;
    count_show = '0;
    unique case (op_i)
      OP_ALLOC: begin
        if (|depth_i) begin
          ctrl_o.pop    = 1'b1;
          ctrl_o.cnt_we = 1'b1;
          page_o        = stack_rd_i;
          count_wr_o    = CntW'(1);
          count_show    = CntW'(1);
          show_page     = 1'b1;
          status_o      = ST_OK;
        end else if ((fresh_w > first_w) && (|fresh_i)) begin
          ctrl_o.take_fresh = 1'b1;
          ctrl_o.cnt_we     = 1'b1;
          page_o            = fresh_dec[IdxW-1:0];
          count_wr_o        = CntW'(1);
          count_show        = CntW'(1);
          show_page         = 1'b1;
          status_o          = ST_OK;
        end else begin
          status_o = ST_NOMEM;
        end
      end
      OP_FREE: begin
        if (in_range) begin
          show_page = 1'b1;
          if (count_rd_i == '0) begin
            status_o = ST_UNDER;
          end else begin
            ctrl_o.cnt_we = 1'b1;
            count_wr_o    = count_rd_i - 1'b1;
            count_show    = count_rd_i - 1'b1;
            // last reference gone: page goes back on the stack if there is room
            ctrl_o.push   = (count_rd_i == CntW'(1)) && !depth_full;
            status_o      = ST_OK;
          end
        end
      end
      OP_REF: begin
        if (in_range) begin
          show_page = 1'b1;
          if (count_rd_i >= CntW'(MAX_REFS)) begin
            status_o   = ST_SAT;
            count_show = count_rd_i;
          end else begin
            ctrl_o.cnt_we = 1'b1;
            count_wr_o    = count_rd_i + 1'b1;
            count_show    = count_rd_i + 1'b1;
            status_o      = ST_OK;
          end
        end
      end
      default: begin
        status_o = ST_BADADDR;
      end
    endcase
  end

  // Result fields
  assign page_w      = show_page ? (WideW'(page_o) << PageShift) : '0;
  assign count_w     = WideW'(count_show);
  assign page_addr_o = page_w[AddrW-1:0];
  assign ref_count_o = count_w[RefOutW-1:0];

endmodule

// File: src/refcounted_page_allocator.sv
// Reference-counted page-frame allocator, top level.
// Holds the count and freed-page memories, the sequencer and the output register.
// Depends on rpa_pkg and rpa_update.

// Each request is handled as a read and then an update: the cycle it is accepted
// reads the page count memory and the freed-page stack; in the execute state, once
// the result register can take the answer, the block updates and writes them back
// and loads the result register. No new request is accepted until that is done. That
// read-then-write of the count memory sets the rate. After reset the count memory
// is cleared one entry per cycle with in_stall_o high; configuration writes are
// taken throughout. PAGE_BYTES must be a power of two.
module refcounted_page_allocator #(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_REFS   = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rpa_pkg::RegW-1:0]        cfg_data_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [rpa_pkg::OpW-1:0]         op_i,
  input  logic [rpa_pkg::AddrW-1:0]       addr_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [rpa_pkg::StatusW-1:0]     status_o,
  output logic [rpa_pkg::AddrW-1:0]       page_addr_o,
  output logic [rpa_pkg::RefOutW-1:0]     ref_count_o
);
  import rpa_pkg::*;

  localparam int unsigned IdxW      = $clog2(NUM_PAGES);
  localparam int unsigned CntW      = $clog2(MAX_REFS + 1);
  localparam int unsigned PageShift = $clog2(PAGE_BYTES);

  state_e              state_q, state_d;
  logic [IdxW-1:0]     clr_idx_q;
  logic [RegW-1:0]     first_q;
  logic [IdxW:0]       depth_q, depth_d;
  logic [IdxW:0]       fresh_q, fresh_d;
  op_e                 op_q;
  logic [AddrW-1:0]    addr_q;

  logic [CntW-1:0]     cnt_mem [NUM_PAGES];
  logic [IdxW-1:0]     stack_mem [NUM_PAGES];
  logic [CntW-1:0]     cnt_rd_q;
  logic [IdxW-1:0]     stk_rd_q;

  logic                out_valid_q;
  logic [StatusW-1:0]  status_q;
  logic [AddrW-1:0]    page_addr_q;
  logic [RefOutW-1:0]  ref_count_q;

  logic                accept;
  logic                out_free;
  logic                done;
  logic [WideW-1:0]    rd_page_w;
  logic [IdxW:0]       depth_dec;

  upd_ctrl_t           upd_ctrl;
  logic [IdxW-1:0]     upd_page;
  logic [CntW-1:0]     upd_count;
  status_e             upd_status;
  logic [AddrW-1:0]    upd_page_addr;
  logic [RefOutW-1:0]  upd_ref_count;

  // Handshakes
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign done        = (state_q == S_EXEC) && out_free;
  assign cfg_ready_o = 1'b1;

  // Read addresses
  assign rd_page_w = WideW'(addr_i[AddrW-1:PageShift]);
  assign depth_dec = depth_q - 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= FirstUsableReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      first_q <= cfg_data_i;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_idx_q == IdxW'(NUM_PAGES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (done) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(op_i);
      addr_q <= addr_i;
    end
  end

  // Memory reads, issued on accept and held until the next one
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cnt_rd_q <= cnt_mem[rd_page_w[IdxW-1:0]];
      stk_rd_q <= stack_mem[depth_dec[IdxW-1:0]];
    end
  end

  // Count memory write: clearing pass, then updates
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      cnt_mem[clr_idx_q] <= '0;
    end else if (done && upd_ctrl.cnt_we) begin
      cnt_mem[upd_page] <= upd_count;
    end
  end

  // Freed-page stack write
  always_ff @(posedge clk_i) begin
    if (done && upd_ctrl.push) begin
      stack_mem[depth_q[IdxW-1:0]] <= upd_page;
    end
  end

  // Update logic
  rpa_update #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_REFS   (MAX_REFS)
  ) u_update (
    .op_i           (op_q),
    .addr_i         (addr_q),
    .first_usable_i (first_q),
    .count_rd_i     (cnt_rd_q),
    .stack_rd_i     (stk_rd_q),
    .depth_i        (depth_q),
    .fresh_i        (fresh_q),
    .ctrl_o         (upd_ctrl),
    .page_o         (upd_page),
    .count_wr_o     (upd_count),
    .status_o       (upd_status),
    .page_addr_o    (upd_page_addr),
    .ref_count_o    (upd_ref_count)
  );

  // Stack depth and fresh pointer
  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    if (upd_ctrl.pop)        depth_d = depth_q - 1'b1;
    else if (upd_ctrl.push)  depth_d = depth_q + 1'b1;
    if (upd_ctrl.take_fresh) fresh_d = fresh_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= (IdxW+1)'(NUM_PAGES);
    end else if (done) begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q    <= upd_status;
      page_addr_q <= upd_page_addr;
      ref_count_q <= upd_ref_count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign page_addr_o = page_addr_q;
  assign ref_count_o = ref_count_q;

endmodule

// File: src/rpa_checker.sv
// Port-level checks for the page allocator result channel, and the bind that attaches them.
// Depends on rpa_pkg and refcounted_page_allocator.
module rpa_checker #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [rpa_pkg::StatusW-1:0]  status_o,
  input logic [rpa_pkg::AddrW-1:0]    page_addr_o,
  input logic [rpa_pkg::RefOutW-1:0]  ref_count_o
);
  import rpa_pkg::*;

  localparam int unsigned PageShift = $clog2(PAGE_BYTES);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(page_addr_o) && $stable(ref_count_o))
    else $error("result changed while stalled");

  // Failures without a page report zeros
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOMEM || status_o == ST_BADADDR) |->
      page_addr_o == '0 && ref_count_o == '0)
    else $error("failure result carries a page");

  // Underflow leaves the count at zero
  a_under_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_UNDER |-> ref_count_o == '0)
    else $error("underflow with nonzero count");

  // Reported pages are page aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> page_addr_o[PageShift-1:0] == '0)
    else $error("unaligned page address");

endmodule

bind refcounted_page_allocator rpa_checker #(
  .PAGE_BYTES (PAGE_BYTES)
) u_rpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .page_addr_o (page_addr_o),
  .ref_count_o (ref_count_o)
);
